// ===== rtl/vtm_pkg.sv =====
// ----------------------------------------------------------------------------
// vtm_pkg
// Shared types and codes for the virtual timer multiplexer.
// ----------------------------------------------------------------------------
`default_nettype none

package vtm_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int MAX_RES        = 16;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] EV_STARTED   = 3'd0;
  localparam logic [2:0] EV_EXPIRED   = 3'd1;
  localparam logic [2:0] EV_CANCELLED = 3'd2;
  localparam logic [2:0] EV_FULL      = 3'd3;
  localparam logic [2:0] EV_BADID     = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] interval;
    logic        repeat_req;
    logic [7:0]  callback_tag;
    logic [3:0]  cancel_id;
  } req_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [3:0] slot;
    logic [7:0] tag;
    logic       last;
  } rsp_t;

  // one timer entry as kept in the slot RAM
  typedef struct packed {
    logic [31:0] deadline;
    logic [31:0] period;
    logic        rep;
    logic [7:0]  tag;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/vtm_ram.sv =====
// ----------------------------------------------------------------------------
// vtm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output      logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/virtual_timer_multiplexer.sv =====
// ----------------------------------------------------------------------------
// virtual_timer_multiplexer
// Many one-shot / periodic virtual timers over one 32-bit microsecond count.
// ----------------------------------------------------------------------------
// Start: the result goes through S_EMIT to the result beat. Cancel: adds S_CRD
// for one slot RAM read of the tag. Tick: each expiry costs one full pass over
// the slot RAM (S_SCAN over all NUM_TIMERS slots, then S_DECIDE), with at most
// 16 expiries per tick; the single read port of the slot RAM sets this.
// One item is in work at a time; req_stall is high until its last beat is
// in the output register.
// Reset (rst, synchronous) clears the count, all valid bits and the FSM.
`default_nettype none

module virtual_timer_multiplexer
  import vtm_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output      logic req_stall,
  input  wire req_t req,
  output      logic rsp_valid,
  input  wire logic rsp_stall,
  output      rsp_t rsp
);

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int PW = $clog2(NUM_TIMERS + 1);   // pointer / count width
  localparam int EW = $bits(entry_t);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CRD    = 3'd1;  // cancel: wait for tag read
  localparam logic [2:0] S_EMIT   = 3'd2;  // push res to output register
  localparam logic [2:0] S_SCAN   = 3'd3;  // sweep all slots for best due
  localparam logic [2:0] S_DECIDE = 3'd4;  // retire best, emit previous

  logic [2:0]           state;
  logic [31:0]          now_count;
  logic [NUM_TIMERS-1:0] valid;
  logic [AW-1:0]        rank [NUM_TIMERS];

  rsp_t                 res;
  logic [AW-1:0]        cslot;

  // scan bookkeeping
  logic [PW-1:0]        ptr;
  logic                 found;
  logic [AW-1:0]        best;
  entry_t               best_e;
  logic [4:0]           k;
  logic                 pend;
  logic [AW-1:0]        pend_slot;
  logic [7:0]           pend_tag;

  // slot RAM
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  entry_t               wdata, rdata;

  vtm_ram #(.WIDTH(EW), .DEPTH(NUM_TIMERS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic accept, out_free;
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // lowest free slot
  logic          have_free;
  logic [AW-1:0] free_idx;
  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        have_free = 1'b1;
        free_idx  = AW'(i);
      end
    end
  end

  logic [PW-1:0] cnt;
  assign cnt = PW'($countones(valid));

  logic          id_ok;
  logic [AW-1:0] id_idx;
  assign id_idx = AW'(req.cancel_id);
  assign id_ok  = (32'(req.cancel_id) < 32'(NUM_TIMERS)) && valid[id_idx];

  logic [31:0] start_iv;
  assign start_iv = (req.repeat_req && req.interval == 32'd0) ? 32'd1 : req.interval;

  // candidate from the entry read last cycle
  logic          d_on;
  logic [AW-1:0] d_slot;
  logic          better;
  assign d_on   = (state == S_SCAN) && (ptr != '0);
  assign d_slot = AW'(ptr - PW'(1));
  assign better = d_on && valid[d_slot] && (rdata.deadline <= now_count) &&
                  (!found || (rdata.deadline < best_e.deadline) ||
                   (rdata.deadline == best_e.deadline && rank[d_slot] < rank[best]));

  // RAM ports
  always_comb begin
    we    = 1'b0;
    waddr = free_idx;
    wdata = '{deadline: now_count + start_iv, period: start_iv,
              rep: req.repeat_req, tag: req.callback_tag};
    raddr = '0;
    if (state == S_IDLE) begin
      raddr = id_idx;
      we    = accept && req.op == OP_START && have_free;
    end else if (state == S_SCAN) begin
      raddr = (ptr < PW'(NUM_TIMERS)) ? AW'(ptr) : '0;
    end else if (state == S_DECIDE) begin
      waddr = best;
      wdata = best_e;
      wdata.deadline = best_e.deadline + best_e.period;
      we    = found && best_e.rep && (!pend || out_free);
    end
  end

  // rank drop request, applied to all valid slots in parallel
  logic          drop;
  logic [AW-1:0] drop_slot;
  always_comb begin
    drop      = 1'b0;
    drop_slot = best;
    if (state == S_IDLE && accept && req.op == OP_CANCEL && id_ok) begin
      drop      = 1'b1;
      drop_slot = id_idx;
    end else if (state == S_DECIDE && found && (!pend || out_free)) begin
      drop = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_TIMERS; j++) begin
      if (drop && valid[j] && AW'(j) != drop_slot && rank[j] > rank[drop_slot]) begin
        rank[j] <= rank[j] - AW'(1);
      end
    end
    if (state == S_IDLE && accept && req.op == OP_START && have_free) begin
      rank[free_idx] <= AW'(cnt);
    end
    if (state == S_DECIDE && found && (!pend || out_free) && best_e.rep) begin
      rank[best] <= AW'(cnt - PW'(1));  // rearmed: goes to the back
    end
  end

  // output register valid: load on a new beat, clear once taken
  logic rsp_load;
  assign rsp_load = out_free &&
                    ((state == S_EMIT) || (state == S_DECIDE && found && pend));

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      now_count <= '0;
      valid     <= '0;
      ptr       <= '0;
      found     <= 1'b0;
      k         <= '0;
      pend      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.op)
              OP_TICK: begin
                now_count <= now_count + 32'd1;
                k         <= '0;
                pend      <= 1'b0;
                ptr       <= '0;
                found     <= 1'b0;
                state     <= S_SCAN;
              end
              OP_START: begin
                if (have_free) begin
                  valid[free_idx] <= 1'b1;
                  res <= '{event_res: EV_STARTED, slot: 4'(free_idx),
                           tag: req.callback_tag, last: 1'b1};
                end else begin
                  res <= '{event_res: EV_FULL, slot: 4'd0,
                           tag: req.callback_tag, last: 1'b1};
                end
                state <= S_EMIT;
              end
              OP_CANCEL: begin
                if (id_ok) begin
                  valid[id_idx] <= 1'b0;
                  cslot         <= id_idx;
                  state         <= S_CRD;
                end else begin
                  res <= '{event_res: EV_BADID, slot: req.cancel_id,
                           tag: 8'd0, last: 1'b1};
                  state <= S_EMIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CRD: begin
          res   <= '{event_res: EV_CANCELLED, slot: 4'(cslot), tag: rdata.tag, last: 1'b1};
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (better) begin
            found  <= 1'b1;
            best   <= d_slot;
            best_e <= rdata;
          end
          if (ptr == PW'(NUM_TIMERS)) begin
            state <= S_DECIDE;
          end else begin
            ptr <= ptr + PW'(1);
          end
        end
        S_DECIDE: begin
          if (!found) begin
            if (pend) begin
              res   <= '{event_res: EV_EXPIRED, slot: 4'(pend_slot),
                         tag: pend_tag, last: 1'b1};
              state <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end else if (!pend || out_free) begin
            if (pend) begin
              rsp <= '{event_res: EV_EXPIRED, slot: 4'(pend_slot),
                       tag: pend_tag, last: 1'b0};
            end
            if (!best_e.rep) begin
              valid[best] <= 1'b0;
            end
            k <= k + 5'd1;
            if (k + 5'd1 == 5'(MAX_RES)) begin
              pend  <= 1'b0;
              res   <= '{event_res: EV_EXPIRED, slot: 4'(best),
                         tag: best_e.tag, last: 1'b1};
              state <= S_EMIT;
            end else begin
              pend      <= 1'b1;
              pend_slot <= best;
              pend_tag  <= best_e.tag;
              ptr       <= '0;
              found     <= 1'b0;
              state     <= S_SCAN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---- checks ----
  a_ram_write_ctx: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_IDLE || state == S_DECIDE))
    else $error("slot RAM written outside start or retire");

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    k <= 5'(MAX_RES))
    else $error("expiry count beyond limit");

  a_retire_only_due: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && found) |-> (best_e.deadline <= now_count))
    else $error("retiring a timer that is not due");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> (rsp_valid && state == S_IDLE))
    else $error("result beat not issued");

endmodule

`default_nettype wire
